// ===== rtl/lmcrf_pkg.sv =====
// Types, constants, microcode table and lookup functions for the LED chain formatter.
package lmcrf_pkg;

    localparam int MATRIX_CHIPS = 4;
    localparam int ROWS         = 8;
    localparam int IMAGE_BYTES  = ROWS * MATRIX_CHIPS;
    localparam int IMG_AW       = $clog2(IMAGE_BYTES);
    localparam int DIGITS       = 4;
    localparam int UC_AW        = 4;

    localparam logic [UC_AW-1:0] UC_REFRESH = UC_AW'(0);
    localparam logic [UC_AW-1:0] UC_INIT    = UC_AW'(8);

    typedef enum logic [2:0] {
        MODE_WRITE   = 3'd0,
        MODE_CHAR    = 3'd1,
        MODE_LEDS    = 3'd2,
        MODE_REFRESH = 3'd3,
        MODE_INIT    = 3'd4,
        MODE_CLEAR   = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        CFG_MATRIX_INTENSITY = 2'd0,
        CFG_AUX_INTENSITY    = 2'd1,
        CFG_SCAN_LIMIT       = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        MAT_ZERO,
        MAT_IMAGE,
        MAT_INTENS,
        MAT_SCAN,
        MAT_ONE
    } mat_sel_t;

    typedef enum logic [2:0] {
        AUX_ZERO,
        AUX_DIGIT,
        AUX_LED_LO,
        AUX_LED_HI,
        AUX_INTENS,
        AUX_SCAN,
        AUX_ONE
    } aux_sel_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [4:0]  index;
        logic [7:0]  value;
        logic [11:0] led_bits;
        logic        first_char;
    } in_item_t;

    typedef struct packed {
        logic [15:0] command_word;
        logic [2:0]  chip_position;
        logic        frame_end;
        logic        last;
    } out_item_t;

    // one control word per frame; the position counter walks the chain inside it
    typedef struct packed {
        logic [3:0] reg_addr;
        mat_sel_t   mat_sel;
        aux_sel_t   aux_sel;
        logic [2:0] row;
        logic [1:0] dig;
        logic       fin;
    } ucode_t;

    localparam logic [7:0] LED_PERM [8] = '{
        8'h08, 8'h80, 8'h04, 8'h10, 8'h01, 8'h20, 8'h02, 8'h40
    };

    localparam logic [6:0] SEG_TABLE [10] = '{
        7'b1111110, 7'b0110000, 7'b1101101, 7'b1111001, 7'b0110011,
        7'b1011011, 7'b1011111, 7'b1110000, 7'b1111111, 7'b1111011
    };

    localparam logic [7:0] DP_MASK = 8'h80;

    function automatic logic [7:0] permute_leds(input logic [7:0] b);
        logic [7:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i])
                r = r | LED_PERM[i];
        end
        return r;
    endfunction

    function automatic ucode_t ucode_rom(input logic [UC_AW-1:0] addr);
        ucode_t w;
        case (addr)
            // refresh: rows 0..7 -> registers 8..1
            4'd0:    w = '{4'h8, MAT_IMAGE,  AUX_ZERO,   3'd0, 2'd0, 1'b0};
            4'd1:    w = '{4'h7, MAT_IMAGE,  AUX_ZERO,   3'd1, 2'd0, 1'b0};
            4'd2:    w = '{4'h6, MAT_IMAGE,  AUX_LED_HI, 3'd2, 2'd0, 1'b0};
            4'd3:    w = '{4'h5, MAT_IMAGE,  AUX_LED_LO, 3'd3, 2'd0, 1'b0};
            4'd4:    w = '{4'h4, MAT_IMAGE,  AUX_DIGIT,  3'd4, 2'd3, 1'b0};
            4'd5:    w = '{4'h3, MAT_IMAGE,  AUX_DIGIT,  3'd5, 2'd2, 1'b0};
            4'd6:    w = '{4'h2, MAT_IMAGE,  AUX_DIGIT,  3'd6, 2'd1, 1'b0};
            4'd7:    w = '{4'h1, MAT_IMAGE,  AUX_DIGIT,  3'd7, 2'd0, 1'b1};
            // init: test off, decode off, intensity, scan limit, shutdown off
            4'd8:    w = '{4'hF, MAT_ZERO,   AUX_ZERO,   3'd0, 2'd0, 1'b0};
            4'd9:    w = '{4'h9, MAT_ZERO,   AUX_ZERO,   3'd0, 2'd0, 1'b0};
            4'd10:   w = '{4'hA, MAT_INTENS, AUX_INTENS, 3'd0, 2'd0, 1'b0};
            4'd11:   w = '{4'hB, MAT_SCAN,   AUX_SCAN,   3'd0, 2'd0, 1'b0};
            4'd12:   w = '{4'hC, MAT_ONE,    AUX_ONE,    3'd0, 2'd0, 1'b1};
            default: w = '{4'h0, MAT_ZERO,   AUX_ZERO,   3'd0, 2'd0, 1'b1};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/led_matrix_chain_refresh_formatter.sv =====
// Image, digit and LED store with a microcoded sequencer that emits chain command words.
//
//  port group   dir  handshake          word
//  in_*         in   in_valid/in_stall  in_item_t: mode, index, value, led_bits, first_char
//  out_*        out  out_valid/out_stall out_item_t: command_word, chip_position, frame_end, last
//  cfg_*        in   cfg_valid/cfg_ready cfg_index selects register, cfg_data is the value
//
// Store, character and LED items update registers on acceptance. Refresh emits 40 words and
// init 25, one word per cycle when not stalled, from the single output register; the run
// length is set by the microcode program (one step per frame) and the chain position counter.
// in_stall is high while a run is in progress. Output stalls hold the sequencer.
// Reset clears the image, digits, LEDs and count and loads register defaults.
module led_matrix_chain_refresh_formatter
    import lmcrf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_data
);

    logic [7:0]       image_reg [IMAGE_BYTES];
    logic [7:0]       digit_reg [DIGITS];
    logic [11:0]      led_reg;
    logic [2:0]       count_reg, count_next;
    logic [3:0]       mint_reg;
    logic [3:0]       aint_reg;
    logic [2:0]       scan_reg;
    logic             busy_reg, busy_next;
    logic [UC_AW-1:0] upc_reg, upc_next;
    logic [2:0]       pos_reg, pos_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_reg, out_next;

    logic             in_accept;
    logic             cfg_accept;
    logic             advance;
    ucode_t           cw;
    logic [IMG_AW-1:0] img_addr;
    logic [7:0]       mat_data;
    logic [7:0]       aux_data;
    logic [7:0]       word_data;
    logic [2:0]       cnt;
    logic             char_is_digit;
    logic [3:0]       digit_val;

    assign in_stall   = busy_reg;
    assign cfg_ready  = !busy_reg;
    assign in_accept  = in_valid && !in_stall;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_reg;
    assign advance    = busy_reg && (!out_valid_reg || !out_stall);

    assign cw       = ucode_rom(upc_reg);
    assign img_addr = IMG_AW'(int'(cw.row) * MATRIX_CHIPS + int'(pos_reg));

    // character decode
    assign cnt           = in_data.first_char ? 3'd0 : count_reg;
    assign char_is_digit = (in_data.value >= 8'h30) && (in_data.value <= 8'h39);
    assign digit_val     = 4'(in_data.value - 8'h30);

    always_comb
    begin
        case (cw.mat_sel)
            MAT_ZERO:   mat_data = 8'h00;
            MAT_IMAGE:  mat_data = image_reg[img_addr];
            MAT_INTENS: mat_data = {4'h0, mint_reg};
            MAT_SCAN:   mat_data = {5'h00, scan_reg};
            MAT_ONE:    mat_data = 8'h01;
            default:    mat_data = 8'h00;
        endcase
        case (cw.aux_sel)
            AUX_ZERO:   aux_data = 8'h00;
            AUX_DIGIT:  aux_data = digit_reg[cw.dig];
            AUX_LED_LO: aux_data = permute_leds(led_reg[7:0]);
            AUX_LED_HI: aux_data = permute_leds({led_reg[11:8], 4'h0});
            AUX_INTENS: aux_data = {4'h0, aint_reg};
            AUX_SCAN:   aux_data = {5'h00, scan_reg};
            AUX_ONE:    aux_data = 8'h01;
            default:    aux_data = 8'h00;
        endcase
        word_data = (int'(pos_reg) == MATRIX_CHIPS) ? aux_data : mat_data;
    end

    // sequencer
    always_comb
    begin
        busy_next      = busy_reg;
        upc_next       = upc_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;

        if (advance) begin
            out_valid_next         = 1'b1;
            out_next.command_word  = {4'h0, cw.reg_addr, word_data};
            out_next.chip_position = pos_reg;
            out_next.frame_end     = (pos_reg == 3'd0);
            out_next.last          = (pos_reg == 3'd0) && cw.fin;
            if (pos_reg == 3'd0) begin
                pos_next = 3'(MATRIX_CHIPS);
                if (cw.fin)
                    busy_next = 1'b0;
                else
                    upc_next = upc_reg + UC_AW'(1);
            end else begin
                pos_next = pos_reg - 3'd1;
            end
        end

        if (in_accept) begin
            case (in_data.mode)
                MODE_REFRESH:
                begin
                    busy_next = 1'b1;
                    upc_next  = UC_REFRESH;
                    pos_next  = 3'(MATRIX_CHIPS);
                end
                MODE_INIT:
                begin
                    busy_next = 1'b1;
                    upc_next  = UC_INIT;
                    pos_next  = 3'(MATRIX_CHIPS);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (in_accept && in_data.mode == MODE_CHAR) begin
            count_next = cnt;
            if (cnt < 3'(DIGITS) && char_is_digit)
                count_next = cnt + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg      <= 1'b0;
            upc_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            led_reg       <= '0;
            mint_reg      <= 4'd0;
            aint_reg      <= 4'd8;
            scan_reg      <= 3'd7;
            for (int i = 0; i < IMAGE_BYTES; i++)
                image_reg[i] <= '0;
            for (int i = 0; i < DIGITS; i++)
                digit_reg[i] <= '0;
        end else begin
            busy_reg      <= busy_next;
            upc_reg       <= upc_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;

            if (cfg_accept) begin
                case (cfg_index)
                    CFG_MATRIX_INTENSITY: mint_reg <= cfg_data;
                    CFG_AUX_INTENSITY:    aint_reg <= cfg_data;
                    CFG_SCAN_LIMIT:       scan_reg <= cfg_data[2:0];
                    default:
                    begin
                    end
                endcase
            end

            if (in_accept) begin
                case (in_data.mode)
                    MODE_WRITE:
                    begin
                        if ({1'b0, in_data.index} < 6'(IMAGE_BYTES))
                            image_reg[IMG_AW'(in_data.index)] <= in_data.value;
                    end
                    MODE_CHAR:
                    begin
                        if (cnt < 3'(DIGITS)) begin
                            if (char_is_digit)
                                digit_reg[cnt[1:0]] <= {1'b0, SEG_TABLE[digit_val]};
                            else if (in_data.value == 8'h2E && cnt != 3'd0)
                                digit_reg[2'(cnt - 3'd1)] <=
                                    digit_reg[2'(cnt - 3'd1)] | DP_MASK;
                        end
                    end
                    MODE_LEDS:
                        led_reg <= in_data.led_bits;
                    MODE_CLEAR:
                    begin
                        for (int i = 0; i < IMAGE_BYTES; i++)
                            image_reg[i] <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the LED chain refresh formatter: directed table, then random phases.
`timescale 1ns / 1ps

module tb_top;
    import lmcrf_pkg::*;

    localparam int          LIMIT_CYCLES  = 2000000;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          PHASE_ITEMS   = 102;
    localparam int          DIR_ROWS      = 25;
    localparam int          MAX_REPORTS   = 40;

    localparam logic [2:0]  MODE_SPARE_A  = 3'd6;
    localparam logic [2:0]  MODE_SPARE_B  = 3'd7;
    localparam logic [1:0]  CFG_SPARE_IDX = 2'd3;

    // driver chip register addresses
    localparam logic [3:0]  REG_DECODE    = 4'h9;
    localparam logic [3:0]  REG_INTENSITY = 4'hA;
    localparam logic [3:0]  REG_SCAN      = 4'hB;
    localparam logic [3:0]  REG_SHUTDOWN  = 4'hC;
    localparam logic [3:0]  REG_TEST      = 4'hF;

    localparam logic [7:0]  CH_0          = 8'h30;
    localparam logic [7:0]  CH_DOT        = 8'h2E;
    localparam logic [7:0]  CH_A          = 8'h41;

    typedef struct {
        in_item_t    item;
        bit          typed;
        logic [15:0] last_word;
    } dir_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    in_item_t   in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_item_t  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [3:0] cfg_data = '0;

    // typed expectation for the last word of a run, travels with the input word
    bit          in_typed = 1'b0;
    logic [15:0] in_last_word = '0;

    // predictor state
    logic [7:0]  img_bytes [IMAGE_BYTES];
    logic [7:0]  seg_codes [DIGITS];
    logic [11:0] led_word;
    logic [2:0]  digits_taken;
    logic [3:0]  matrix_level;
    logic [3:0]  aux_level;
    logic [2:0]  scan_depth;
    logic [7:0]  frame_bytes [MATRIX_CHIPS+1];

    out_item_t   exp_words [$];
    int          err_count = 0;
    int unsigned cycle_cnt = 0;
    int          stall_left = 0;
    int          str_left = 0;
    bit          stall_en = 1'b0;
    bit          gap_en = 1'b0;
    dir_row_t    dir_tab [DIR_ROWS];

    led_matrix_chain_refresh_formatter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // output backpressure: bursts of random length, mostly short
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left <= stall_left - 1;
        else
        begin
            out_stall <= stall_en && ($urandom_range(0, 2) == 0);
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20)
                                                      : $urandom_range(0, 3);
        end
    end

    function automatic logic [7:0] seg_code(input logic [3:0] d);
        case (d)
            4'd0:    return 8'h7E;
            4'd1:    return 8'h30;
            4'd2:    return 8'h6D;
            4'd3:    return 8'h79;
            4'd4:    return 8'h33;
            4'd5:    return 8'h5B;
            4'd6:    return 8'h5F;
            4'd7:    return 8'h70;
            4'd8:    return 8'h7F;
            default: return 8'h7B;
        endcase
    endfunction

    // LED bit scatter onto the aux chip's segment lines
    function automatic logic [7:0] scatter_leds(input logic [7:0] b);
        return {b[1], b[7], b[5], b[3], b[0], b[2], b[6], b[4]};
    endfunction

    function automatic in_item_t mk(input logic [2:0] m, input logic [4:0] idx,
                                    input logic [7:0] v, input logic [11:0] l,
                                    input logic f);
        in_item_t it;
        it.mode       = m;
        it.index      = idx;
        it.value      = v;
        it.led_bits   = l;
        it.first_char = f;
        return it;
    endfunction

    task automatic clear_model();
        foreach (img_bytes[i])
            img_bytes[i] = '0;
        foreach (seg_codes[i])
            seg_codes[i] = '0;
        led_word     = '0;
        digits_taken = '0;
        matrix_level = 4'd0;
        aux_level    = 4'd8;
        scan_depth   = 3'd7;
    endtask

    task automatic fill_frame(input logic [7:0] b);
        foreach (frame_bytes[i])
            frame_bytes[i] = b;
    endtask

    task automatic emit_frame(input logic [3:0] reg_a, input bit closing);
        out_item_t w;
        for (int p = MATRIX_CHIPS; p >= 0; p--)
        begin
            w.command_word  = {4'h0, reg_a, frame_bytes[p]};
            w.chip_position = p[2:0];
            w.frame_end     = (p == 0);
            w.last          = closing && (p == 0);
            exp_words.push_back(w);
        end
    endtask

    task automatic predict_words(input in_item_t it);
        logic [7:0] aux_rows [8];
        case (it.mode)
            MODE_WRITE:
                if (it.index < IMAGE_BYTES)
                    img_bytes[it.index] = it.value;
            MODE_CHAR:
            begin
                if (it.first_char)
                    digits_taken = '0;
                if (digits_taken < DIGITS)
                begin
                    if (it.value >= CH_0 && it.value <= CH_0 + 9)
                    begin
                        seg_codes[digits_taken[1:0]] = seg_code(4'(it.value - CH_0));
                        digits_taken = digits_taken + 3'd1;
                    end
                    else if (it.value == CH_DOT && digits_taken != 0)
                        seg_codes[2'(digits_taken - 3'd1)][7] = 1'b1;
                end
            end
            MODE_LEDS:
                led_word = it.led_bits;
            MODE_REFRESH:
            begin
                for (int d = 0; d < DIGITS; d++)
                    aux_rows[d] = seg_codes[d];
                aux_rows[4] = scatter_leds(led_word[7:0]);
                aux_rows[5] = scatter_leds({led_word[11:8], 4'h0});
                aux_rows[6] = '0;
                aux_rows[7] = '0;
                for (int f = 0; f < ROWS; f++)
                begin
                    for (int c = 0; c < MATRIX_CHIPS; c++)
                        frame_bytes[c] = img_bytes[f * MATRIX_CHIPS + c];
                    frame_bytes[MATRIX_CHIPS] = aux_rows[7 - f];
                    emit_frame(4'(ROWS - f), f == ROWS - 1);
                end
            end
            MODE_INIT:
            begin
                fill_frame(8'h00);
                emit_frame(REG_TEST, 1'b0);
                emit_frame(REG_DECODE, 1'b0);
                fill_frame({4'h0, matrix_level});
                frame_bytes[MATRIX_CHIPS] = {4'h0, aux_level};
                emit_frame(REG_INTENSITY, 1'b0);
                fill_frame({5'h0, scan_depth});
                emit_frame(REG_SCAN, 1'b0);
                fill_frame(8'h01);
                emit_frame(REG_SHUTDOWN, 1'b1);
            end
            MODE_CLEAR:
                foreach (img_bytes[i])
                    img_bytes[i] = '0;
            default:
                ;
        endcase
    endtask

    task automatic apply_reg(input logic [1:0] idx, input logic [3:0] d);
        case (idx)
            CFG_MATRIX_INTENSITY: matrix_level = d;
            CFG_AUX_INTENSITY:    aux_level = d;
            CFG_SCAN_LIMIT:       scan_depth = d[2:0];
            default:              ;
        endcase
    endtask

    task automatic report(input string field, input logic [15:0] want, input logic [15:0] got);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    endtask

    task automatic check_word(input out_item_t got);
        out_item_t want;
        if (exp_words.size() == 0)
        begin
            err_count++;
            if (err_count <= MAX_REPORTS)
                $display("%0t: unexpected word, expected none, got %h", $time, got);
        end
        else
        begin
            want = exp_words.pop_front();
            if (got.command_word !== want.command_word)
                report("command_word", want.command_word, got.command_word);
            if (got.chip_position !== want.chip_position)
                report("chip_position", 16'(want.chip_position), 16'(got.chip_position));
            if (got.frame_end !== want.frame_end)
                report("frame_end", 16'(want.frame_end), 16'(got.frame_end));
            if (got.last !== want.last)
                report("last", 16'(want.last), 16'(got.last));
        end
    endtask

    // all handshakes are observed here, on pre-edge values
    always @(posedge clk)
    begin
        out_item_t tail;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_word(out_data);
            if (cfg_valid && cfg_ready)
                apply_reg(cfg_index, cfg_data);
            if (in_valid && !in_stall)
            begin
                predict_words(in_data);
                if (in_typed && exp_words.size() != 0)
                begin
                    tail = exp_words.pop_back();
                    tail.command_word = in_last_word;
                    exp_words.push_back(tail);
                end
            end
        end
    end

    task automatic send_item(input in_item_t it, input bit typed, input logic [15:0] tword);
        in_valid     <= 1'b1;
        in_data      <= it;
        in_typed     <= typed;
        in_last_word <= tword;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic sender_gap();
        int n;
        n = 0;
        if (gap_en && $urandom_range(0, 9) >= 6)
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // hold off the sender until every expected word has come out
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (exp_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [3:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic program_regs(input logic [3:0] mi, input logic [3:0] ai, input logic [2:0] sl);
        write_reg(CFG_MATRIX_INTENSITY, mi);
        write_reg(CFG_AUX_INTENSITY, ai);
        write_reg(CFG_SCAN_LIMIT, {1'b0, sl});
        write_reg(CFG_SPARE_IDX, 4'($urandom_range(0, 15)));
        cfg_valid <= 1'b0;
    endtask

    function automatic in_item_t rand_item();
        in_item_t    it;
        int unsigned pick;
        int unsigned cls;
        it = mk(3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)),
                1'($urandom_range(0, 1)));
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            // well-formed digit strings with mostly digits and dots
            it.mode = MODE_CHAR;
            it.first_char = (str_left == 0);
            if (str_left == 0)
                str_left = $urandom_range(1, 7);
            str_left--;
            cls = $urandom_range(0, 19);
            if (cls < 14)
                it.value = CH_0 + 8'($urandom_range(0, 9));
            else if (cls < 17)
                it.value = CH_DOT;
        end
        else if (pick < 62)
            it.mode = MODE_WRITE;
        else if (pick < 70)
            it.mode = MODE_LEDS;
        else if (pick < 80)
            it.mode = MODE_REFRESH;
        else if (pick < 85)
            it.mode = MODE_INIT;
        else if (pick < 88)
            it.mode = MODE_CLEAR;
        else if (pick < 92)
            it.mode = MODE_CHAR;
        return it;
    endfunction

    initial
    begin
        clear_model();
        dir_tab = '{
            '{mk(MODE_REFRESH, 5'd0,  8'h00,      12'h000, 1'b0), 1'b1, 16'h0100},
            '{mk(MODE_INIT,    5'd0,  8'h00,      12'h000, 1'b0), 1'b1, 16'h0C01},
            '{mk(MODE_WRITE,   5'd0,  8'hFF,      12'h000, 1'b0), 1'b0, 16'h0000},
            '{mk(MODE_WRITE,   5'd31, 8'h80,      12'h000, 1'b0), 1'b0, 16'h0000},
            '{mk(MODE_WRITE,   5'd28, 8'h01,      12'h000, 1'b0), 1'b0, 16'h0000},
            '{mk(MODE_WRITE,   5'd3,  8'h00,      12'h000, 1'b0), 1'b0, 16'h0000},
            '{mk(MODE_CHAR,    5'd0,  CH_0,       12'h000, 1'b1), 1'b0, 16'h0000},
            '{mk(MODE_CHAR,    5'd0,  CH_DOT,     12'h000, 1'b0), 1'b0, 16'h0000},
            '{mk(MODE_CHAR,    5'd0,  CH_0 + 9,   12'h000, 1'b0), 1'b0, 16'h0000},
            '{mk(MODE_CHAR,    5'd0,  CH_A,       12'h000, 1'b0), 1'b0, 16'h0000},
            '{mk(MODE_CHAR,    5'd0,  CH_0 + 5,   12'h000, 1'b0), 1'b0, 16'h0000},
            '{mk(MODE_CHAR,    5'd0,  8'hFF,      12'h000, 1'b0), 1'b0, 16'h0000},
            '{mk(MODE_CHAR,    5'd0,  CH_0 + 8,   12'h000, 1'b0), 1'b0, 16'h0000},
            '{mk(MODE_CHAR,    5'd0,  CH_0 + 7,   12'h000, 1'b0), 1'b0, 16'h0000},
            '{mk(MODE_CHAR,    5'd0,  CH_DOT,     12'h000, 1'b0), 1'b0, 16'h0000},
            '{mk(MODE_LEDS,    5'd0,  8'h00,      12'hFFF, 1'b0), 1'b0, 16'h0000},
            '{mk(MODE_REFRESH, 5'd0,  8'h00,      12'h000, 1'b0), 1'b0, 16'h0000},
            '{mk(MODE_LEDS,    5'd0,  8'h00,      12'h5A3, 1'b0), 1'b0, 16'h0000},
            '{mk(MODE_CHAR,    5'd0,  CH_DOT,     12'h000, 1'b1), 1'b0, 16'h0000},
            '{mk(MODE_CHAR,    5'd0,  CH_0 + 3,   12'h000, 1'b0), 1'b0, 16'h0000},
            '{mk(MODE_SPARE_A, 5'd7,  8'h55,      12'h0F0, 1'b1), 1'b0, 16'h0000},
            '{mk(MODE_SPARE_B, 5'd9,  8'hAA,      12'hF0F, 1'b0), 1'b0, 16'h0000},
            '{mk(MODE_REFRESH, 5'd0,  8'h00,      12'h000, 1'b0), 1'b0, 16'h0000},
            '{mk(MODE_CLEAR,   5'd0,  8'h00,      12'h000, 1'b0), 1'b0, 16'h0000},
            '{mk(MODE_REFRESH, 5'd0,  8'h00,      12'h000, 1'b0), 1'b1, 16'h0100}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].last_word);

        for (int ph = 0; ph < 4; ph++)
        begin
            wait_idle();
            if (ph == 0)
                program_regs(4'd0, 4'd0, 3'd0);
            else if (ph == 1)
                program_regs(4'd15, 4'd15, 3'd7);
            else
                program_regs(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                             3'($urandom_range(0, 7)));
            stall_en = (ph != 0);
            gap_en   = (ph != 1);
            // every phase opens with an init so the new settings show up early
            send_item(mk(MODE_INIT, 5'd0, 8'h00, 12'h000, 1'b0), 1'b0, 16'h0000);
            repeat (PHASE_ITEMS)
            begin
                sender_gap();
                send_item(rand_item(), 1'b0, 16'h0000);
            end
        end

        wait_idle();
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/lmcrf_pkg.sv
rtl/led_matrix_chain_refresh_formatter.sv
tb/sv/tb_top.sv
